FILE: hdl/plen_pkg.sv
// Shared types and codes for the positional list engine.
// Beat payload structs, command and status codes, cell control struct.
// No dependencies.
package plen_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LEN_W   = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value_out;
    logic [LEN_W-1:0]         list_length;
  } out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              era;
    logic              rd;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: hdl/plen_cell.sv
// One storage cell of the list chain: holds one entry and takes its
// neighbor's entry on insert or erase. Depends on plen_pkg.
module plen_cell
  import plen_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              hit,       // this cell is the target position
  input  logic              above,     // this cell lies past the target
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] rd_val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins && above) begin
      val_nxt = left_val;
    end else if (ctrl.ins && hit) begin
      val_nxt = ctrl.value;
    end else if (ctrl.era && (hit || above)) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = (ctrl.rd && hit) ? val_r : '0;

endmodule

FILE: hdl/positional_list_engine_top.sv
// Positional list engine top: command decode, length count, cell chain
// and read gather tree. Depends on plen_pkg and plen_cell.
//
// Usage:
//   Input: a beat is taken at a rising edge with start high and busy low.
//   in_data carries cmd (insert/get/erase), a 1-based position and a value.
//   Output: every input beat yields exactly one result beat. out_valid is
//   high for one cycle with out_data (status, value read, list length).
//   The receiver cannot stall; the result must be captured in that cycle.
// Timing:
//   busy stays high through the EXEC and GATHER states after acceptance,
//   so no new beat is taken until both are done. EXEC moves the whole
//   chain in parallel (every cell takes its neighbor's entry) and latches
//   per-group read ORs of 32 cells; GATHER merges the groups into the
//   result register and sets out_valid.
//   A new beat may be accepted in the cycle its predecessor's result shows.
// Reset:
//   Synchronous, active low. The list becomes empty; entry contents stay
//   undefined until written and are never read before that.
module positional_list_engine_top
  import plen_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned GROUP   = 32;
  localparam int unsigned NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_GATHER = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              op_ins_r, op_era_r, op_rd_r;
  logic              op_ins_nxt, op_era_nxt, op_rd_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] val_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [DATA_W-1:0] grp_r   [NGROUPS];
  logic [DATA_W-1:0] grp_nxt [NGROUPS];
  logic [DATA_W-1:0] gather;

  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_rd  [CAPACITY];
  cell_ctrl_t        ctrl;

  logic              accept;
  logic [CMP_W-1:0]  pos_e, cnt_e;
  logic              pos_in_list;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r != S_IDLE);
  assign pos_e       = CMP_W'(in_data.position);
  assign cnt_e       = CMP_W'(count_r);
  assign pos_in_list = (pos_e != '0) && (pos_e <= cnt_e);

  // command decode against the current length
  always_comb begin
    op_ins_nxt = 1'b0;
    op_era_nxt = 1'b0;
    op_rd_nxt  = 1'b0;
    status_nxt = ST_RANGE;
    count_nxt  = count_r;
    case (in_data.cmd)
      CMD_INSERT: begin
        if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
          status_nxt = ST_RANGE;
        end else if (cnt_e >= CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          op_ins_nxt = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (pos_in_list) begin
          status_nxt = ST_OK;
          op_rd_nxt  = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (pos_in_list) begin
          status_nxt = ST_OK;
          op_era_nxt = 1'b1;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign ctrl.ins   = op_ins_r && (state_r == S_EXEC);
  assign ctrl.era   = op_era_r && (state_r == S_EXEC);
  assign ctrl.rd    = op_rd_r  && (state_r == S_EXEC);
  assign ctrl.value = val_r;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic hit, above;
    logic [DATA_W-1:0] left_v, right_v;
    assign hit   = (idx_r == IDX_W'(j));
    assign above = (IDX_W'(j) > idx_r);
    if (j == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = cell_val[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_val[j+1];
    end
    plen_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .hit       (hit),
      .above     (above),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[j]),
      .rd_val    (cell_rd[j])
    );
  end

  // first tree level: OR of the masked reads within each group
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GROUP + k];
        end
      end
    end
  end

  always_comb begin
    gather = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      gather = gather | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      op_ins_r    <= 1'b0;
      op_era_r    <= 1'b0;
      op_rd_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_GATHER);
      if (accept) begin
        count_r  <= count_nxt;
        op_ins_r <= op_ins_nxt;
        op_era_r <= op_era_nxt;
        op_rd_r  <= op_rd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= IDX_W'(in_data.position - POS_W'(1));
      val_r    <= in_data.value_in;
      status_r <= status_nxt;
    end
    if (state_r == S_EXEC) begin
      for (int g = 0; g < NGROUPS; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    if (state_r == S_GATHER) begin
      out_data_r.status      <= status_r;
      out_data_r.value_out   <= op_rd_r ? gather : '0;
      out_data_r.list_length <= LEN_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/plen_checker.sv
// Port-level checker for positional_list_engine_top, attached by bind.
// Depends on plen_pkg.
module plen_checker
  import plen_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted beat did not give a result three cycles later");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("engine not busy after accepting a beat");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.value_out == '0))
    else $error("failed operation returned a nonzero value");

endmodule

bind positional_list_engine_top plen_checker u_plen_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
